// ===== rtl/kfm_pkg.sv =====
// Package with keyword table, sizes and case folding for the keyword filter matcher.
`timescale 1ns / 1ps

package kfm_pkg;

    localparam int KEYWORD_COUNT   = 5;
    localparam int MAX_KEYWORD_LEN = 16;
    localparam int HIST_DEPTH      = MAX_KEYWORD_LEN - 1;
    localparam int LEN_W           = $clog2(MAX_KEYWORD_LEN + 1);

    typedef logic [7:0]               byte_t;
    typedef logic [KEYWORD_COUNT-1:0] mask_t;
    typedef logic [LEN_W-1:0]         kw_len_t;

    localparam kw_len_t KW_LEN [KEYWORD_COUNT] = '{
        kw_len_t'(10), kw_len_t'(12), kw_len_t'(6), kw_len_t'(16), kw_len_t'(8)
    };

    // Characters in reading order; unused positions are zero.
    localparam byte_t KW_TEXT [KEYWORD_COUNT][MAX_KEYWORD_LEN] = '{
        '{"c", "o", "m", "m", "u", "n", "i", "s", "t", "s",
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"p", "r", "o", "l", "e", "t", "a", "r", "i", "a", "n", "s",
          8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "h", "a", "i", "n", "s",
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"p", "e", "r", "s", "i", "a", "n", "a", "m", "e", "r", "i", "c", "a", "n", "a"},
        '{"a", "s", "d", "s", "a", "d", "a", "d",
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    function automatic byte_t fold_case(input byte_t c);
        byte_t r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage

// ===== rtl/keyword_filter_matcher_top.sv =====
// Top level of the keyword filter matcher: history, comparators and result register.
`timescale 1ns / 1ps
// A word with tlast set yields its mask on m_axis in the cycle after acceptance.
// Throughput: one input word per cycle while s_axis_tready is high; the parallel
// comparators against the history register finish each word in the accepting cycle.
// s_axis_tready drops only while a mask waits in the output register and m_axis is stalled.
// Reset (rst_n low, asynchronous) clears history, flags, string-end mark and output valid.

module keyword_filter_matcher_top
    import kfm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  logic       s_axis_tlast,   // final_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [4:0] found_mask, [7:5] zero
);

    byte_t recent_reg [HIST_DEPTH];
    mask_t flags_reg;
    logic  ended_reg;
    logic  out_valid_reg;
    mask_t out_mask_reg;

    byte_t cur;
    logic  scan;
    logic  accept;
    mask_t hit;
    mask_t flags_next;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cur           = fold_case(s_axis_tdata);
    assign scan          = !ended_reg && (s_axis_tdata != 8'h00);

    always_comb
    begin
        logic  ok;
        byte_t ref_c;
        byte_t hist_c;
        ref_c  = '0;
        hist_c = '0;
        for (int k = 0; k < KEYWORD_COUNT; k++)
        begin
            ok = (KW_LEN[k] != '0) && (int'(KW_LEN[k]) <= MAX_KEYWORD_LEN);
            for (int j = 0; j < MAX_KEYWORD_LEN; j++)
            begin
                ref_c  = '0;
                hist_c = '0;
                if (j < int'(KW_LEN[k]))
                begin
                    ref_c  = KW_TEXT[k][(int'(KW_LEN[k]) - 1 - j) % MAX_KEYWORD_LEN];
                    hist_c = (j == 0) ? cur : recent_reg[(j + HIST_DEPTH - 1) % HIST_DEPTH];
                    if (ref_c != hist_c)
                    begin
                        ok = 1'b0;
                    end
                end
            end
            hit[k] = scan && ok;
        end
        flags_next = flags_reg | hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                recent_reg[i] <= '0;
            end
            flags_reg <= '0;
            ended_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (s_axis_tlast)
            begin
                for (int i = 0; i < HIST_DEPTH; i++)
                begin
                    recent_reg[i] <= '0;
                end
                flags_reg <= '0;
                ended_reg <= 1'b0;
            end
            else
            begin
                flags_reg <= flags_next;
                if (scan)
                begin
                    recent_reg[0] <= cur;
                    for (int i = 1; i < HIST_DEPTH; i++)
                    begin
                        recent_reg[i] <= recent_reg[i-1];
                    end
                end
                else
                begin
                    ended_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && s_axis_tlast)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && s_axis_tlast)
        begin
            out_mask_reg <= flags_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(8 - KEYWORD_COUNT)'(0), out_mask_reg};

endmodule

// ===== rtl/kfm_checker.sv =====
// Port-level checker for the keyword filter matcher, bound to the top level.
`timescale 1ns / 1ps

module kfm_checker
    import kfm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    logic s_acc;
    assign s_acc = s_axis_tvalid && s_axis_tready;

    // Hold a stalled result word.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && s_axis_tlast |=> m_axis_tvalid)
        else $error("no result after last word");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && !s_axis_tlast && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result without last word");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:KEYWORD_COUNT] == '0))
        else $error("padding bits set in result word");

endmodule

bind keyword_filter_matcher_top kfm_checker u_kfm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
